/* src/rcrr_pkg.sv */
package rcrr_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_KNOWN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHYSICAL_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LIMIT = 3'd4;

	localparam logic CMD_RESERVE = 1'b0;
	localparam logic CMD_REFUND = 1'b1;

	localparam logic [2:0] KIND_READ = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_TRIM = 3'd2;
	localparam logic [2:0] KIND_FENCE = 3'd3;

	localparam logic [5:0] INNER_CEIL = 6'd32;
	localparam logic [4:0] SMALL_CEIL = 5'd31;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_INVALID = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_FULL = 3'd3,
		ST_EXHAUSTED = 3'd4,
		ST_INVARIANT = 3'd5
	} status_t;

	typedef struct packed {
		logic [5:0] inner;
		logic [4:0] physical;
		logic [4:0] cache;
		logic [4:0] record;
	} credit_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctrl_sts_t;

endpackage

/* src/rcrr_ctrl.sv */
module rcrr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rcrr_pkg::ctrl_sts_t sts,
	output rcrr_pkg::ctrl_cmd_t cmd
);
	import rcrr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/rcrr_dp.sv */
module rcrr_dp #(
	parameter int SLOT_COUNT = 16,
	parameter int ATOM_COUNT = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcrr_pkg::ctrl_cmd_t                 cmd,
	output rcrr_pkg::ctrl_sts_t                 sts,
	input  logic                                cfg_we,
	input  logic [rcrr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcrr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                command,
	input  logic [3:0]                          slot,
	input  logic [2:0]                          kind,
	input  logic [7:0]                          touch_mask,
	input  logic [7:0]                          atom_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          status,
	output logic [5:0]                          inner_cost,
	output logic [4:0]                          physical_cost,
	output logic [4:0]                          cache_cost,
	output logic [4:0]                          record_cost
);
	import rcrr_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int XW = (IW > 4) ? IW : 4;
	localparam logic [7:0] LIVE_MASK = 8'((9'd1 << ATOM_COUNT) - 9'd1);

	logic            record_known_q;
	logic [15:0]     record_limit_q;
	logic [15:0]     inner_limit_q;
	logic [15:0]     physical_limit_q;
	logic [15:0]     cache_limit_q;

	logic [5:0]      inner_used_q;
	logic [4:0]      physical_used_q;
	logic [4:0]      cache_used_q;
	logic [15:0]     record_used_q;

	credit_t         mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] rsv_q;

	logic            cmd_q;
	logic [2:0]      kind_q;
	logic [7:0]      mask_q;
	logic            atom_ok_q;
	logic            in_range_q;
	logic [IW-1:0]   idx_q;
	credit_t         ent_q;
	logic            ent_rsv_q;

	logic            out_valid_q;
	status_t         status_q;
	credit_t         out_q;

	logic [XW-1:0]   slot_x;
	logic [IW-1:0]   idx;
	logic [3:0]      n;
	credit_t         c;
	logic            well;
	logic            wr_or_trim;
	logic [16:0]     rec_sum;
	logic [6:0]      inner_sum;
	logic [5:0]      phys_sum;
	logic [5:0]      cache_sum;
	logic [5:0]      inner_cap;
	logic [4:0]      phys_cap;
	logic [4:0]      cache_cap;
	logic            under;
	status_t         st;
	credit_t         res;
	logic            do_reserve;
	logic            do_refund;

	assign slot_x = XW'(slot);
	assign idx = slot_x[IW-1:0];

	always_comb begin
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, mask_q[i] & LIVE_MASK[i]};
		end
		c = '0;
		well = 1'b1;
		unique case (kind_q)
			KIND_READ: begin
				c.inner = 6'd2;
				c.cache = 5'd1;
				well = atom_ok_q;
			end
			KIND_WRITE: begin
				c.inner = {n, 2'b00};
				c.physical = {n, 1'b0};
				c.cache = {n, 1'b0};
				c.record = {n, 1'b0};
				well = (n != 4'd0);
			end
			KIND_TRIM: begin
				c.inner = {1'b0, n, 1'b0};
				c.physical = {1'b0, n};
				c.cache = {1'b0, n};
				c.record = {1'b0, n};
				well = (n != 4'd0);
			end
			KIND_FENCE: well = 1'b1;
			default: well = 1'b0;
		endcase
	end

	assign wr_or_trim = (kind_q == KIND_WRITE) || (kind_q == KIND_TRIM);
	assign rec_sum = {1'b0, record_used_q} + 17'(c.record);
	assign inner_sum = {1'b0, inner_used_q} + {1'b0, c.inner};
	assign phys_sum = {1'b0, physical_used_q} + {1'b0, c.physical};
	assign cache_sum = {1'b0, cache_used_q} + {1'b0, c.cache};
	assign inner_cap = (inner_limit_q < 16'(INNER_CEIL)) ? inner_limit_q[5:0] : INNER_CEIL;
	assign phys_cap = (physical_limit_q < 16'(SMALL_CEIL)) ? physical_limit_q[4:0] : SMALL_CEIL;
	assign cache_cap = (cache_limit_q < 16'(SMALL_CEIL)) ? cache_limit_q[4:0] : SMALL_CEIL;
	assign under = (inner_used_q < ent_q.inner) || (physical_used_q < ent_q.physical) ||
		(cache_used_q < ent_q.cache) || (record_used_q < 16'(ent_q.record));

	always_comb begin
		st = ST_OK;
		res = '0;
		do_reserve = 1'b0;
		do_refund = 1'b0;
		priority if (!in_range_q) begin
			st = ST_INVALID;
		end else if (cmd_q == CMD_REFUND) begin
			if (ent_rsv_q) begin
				if (under) begin
					st = ST_INVARIANT;
				end else begin
					res = ent_q;
					do_refund = 1'b1;
				end
			end
		end else if (ent_rsv_q || !well) begin
			st = ST_INVALID;
		end else if (!record_known_q && wr_or_trim) begin
			st = ST_UNKNOWN;
		end else if (rec_sum > {1'b0, record_limit_q}) begin
			st = ST_FULL;
		end else if ((inner_sum > {1'b0, inner_cap}) || (phys_sum > {1'b0, phys_cap}) ||
			(cache_sum > {1'b0, cache_cap})) begin
			st = ST_EXHAUSTED;
		end else begin
			res = c;
			do_reserve = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_known_q <= 1'b1;
			record_limit_q <= 16'hFFFF;
			inner_limit_q <= 16'd32;
			physical_limit_q <= 16'd16;
			cache_limit_q <= 16'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RECORD_KNOWN: record_known_q <= cfg_data[0];
				CFG_RECORD_LIMIT: record_limit_q <= cfg_data;
				CFG_INNER_LIMIT: inner_limit_q <= cfg_data;
				CFG_PHYSICAL_LIMIT: physical_limit_q <= cfg_data;
				CFG_CACHE_LIMIT: cache_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			kind_q <= kind;
			mask_q <= touch_mask;
			atom_ok_q <= (32'(atom_index) < ATOM_COUNT);
			idx_q <= idx;
			ent_q <= mem_q[idx];
		end
		if (cmd.exec && do_reserve) begin
			mem_q[idx_q] <= c;
		end
		if (cmd.exec) begin
			status_q <= st;
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q <= 1'b0;
			ent_rsv_q <= 1'b0;
			rsv_q <= '0;
			inner_used_q <= '0;
			physical_used_q <= '0;
			cache_used_q <= '0;
			record_used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				in_range_q <= (32'(slot) < SLOT_COUNT);
				ent_rsv_q <= (32'(slot) < SLOT_COUNT) ? rsv_q[idx] : 1'b0;
			end
			if (cmd.exec && do_reserve) begin
				rsv_q[idx_q] <= 1'b1;
				inner_used_q <= inner_sum[5:0];
				physical_used_q <= phys_sum[4:0];
				cache_used_q <= cache_sum[4:0];
				record_used_q <= rec_sum[15:0];
			end
			if (cmd.exec && do_refund) begin
				rsv_q[idx_q] <= 1'b0;
				inner_used_q <= inner_used_q - ent_q.inner;
				physical_used_q <= physical_used_q - ent_q.physical;
				cache_used_q <= cache_used_q - ent_q.cache;
				record_used_q <= record_used_q - 16'(ent_q.record);
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign inner_cost = out_q.inner;
	assign physical_cost = out_q.physical;
	assign cache_cost = out_q.cache;
	assign record_cost = out_q.record;

endmodule

/* src/request_credit_reserve_refund_top.sv */
// channel  | handshake            | payload
// input    | in_valid / in_stall  | command slot kind touch_mask atom_index
// output   | out_valid / out_stall| status inner_cost physical_cost cache_cost record_cost
// config   | cfg_we               | cfg_index cfg_data
//
// An item passes through the idle state, which captures the beat and reads the slot entry,
// then the exec state, which checks costs, updates the counters and loads the output register.
// A stalled output beat holds the block in its exec state; the next input
// beat is taken while the last result still waits.
// Reset clears counters, slot reservations and restores the register defaults.
module request_credit_reserve_refund_top #(
	parameter int SLOT_COUNT = 16,
	parameter int ATOM_COUNT = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rcrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcrr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [3:0]                      slot,
	input  logic [2:0]                      kind,
	input  logic [7:0]                      touch_mask,
	input  logic [7:0]                      atom_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic [5:0]                      inner_cost,
	output logic [4:0]                      physical_cost,
	output logic [4:0]                      cache_cost,
	output logic [4:0]                      record_cost
);
	import rcrr_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	rcrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rcrr_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.ATOM_COUNT (ATOM_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.slot          (slot),
		.kind          (kind),
		.touch_mask    (touch_mask),
		.atom_index    (atom_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.inner_cost    (inner_cost),
		.physical_cost (physical_cost),
		.cache_cost    (cache_cost),
		.record_cost   (record_cost)
	);

endmodule

/* src/rcrr_chk.sv */
module rcrr_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [2:0]                      status,
	input logic [5:0]                      inner_cost,
	input logic [4:0]                      physical_cost,
	input logic [4:0]                      cache_cost,
	input logic [4:0]                      record_cost
);
	import rcrr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(inner_cost))
	else $error("output beat dropped or changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (inner_cost == 6'd0) && (physical_cost == 5'd0)
		&& (cache_cost == 5'd0) && (record_cost == 5'd0))
	else $error("failed request carries nonzero costs");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_INVALID) || (status == ST_UNKNOWN)
		|| (status == ST_FULL) || (status == ST_EXHAUSTED) || (status == ST_INVARIANT))
	else $error("status code out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
	else $error("second input beat taken while one is in flight");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> ##1 out_valid)
	else $error("result missing after accepted beat");

endmodule

bind request_credit_reserve_refund_top rcrr_chk u_rcrr_chk (.*);

/* tb/sv/request_credit_reserve_refund_top_tb.sv */
`timescale 1ns / 100ps

module request_credit_reserve_refund_top_tb;
	import rcrr_pkg::*;

	localparam int SLOTS = 16;
	localparam int ATOMS = 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 93;

	localparam logic [2:0] KIND_BAD = 3'd4;
	localparam logic [2:0] KIND_BAD_TOP = 3'd7;

	typedef struct packed {
		status_t st;
		credit_t cr;
	} outcome_t;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  cmd;
		logic [3:0]            sl;
		logic [2:0]            kd;
		logic [7:0]            mask;
		logic [7:0]            idx;
		logic                  typed;
		status_t               st;
		credit_t               cr;
	} step_t;

	localparam credit_t NO_CR = '0;
	localparam credit_t READ_CR = '{6'd2, 5'd0, 5'd1, 5'd0};
	localparam credit_t WIDE_WR_CR = '{6'd32, 5'd16, 5'd16, 5'd16};

	localparam step_t SCRIPT [29] = '{
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_REFUND, 4'd0, KIND_FENCE, 8'h00, 8'h00, 1'b1, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd0, KIND_READ, 8'h00, 8'h00, 1'b1, ST_OK, READ_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd0, KIND_FENCE, 8'h00, 8'h00, 1'b1, ST_INVALID, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd1, KIND_BAD, 8'h01, 8'h00, 1'b1, ST_INVALID, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd1, KIND_BAD_TOP, 8'hff, 8'hff, 1'b1, ST_INVALID, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd1, KIND_READ, 8'h00, 8'h08, 1'b1, ST_INVALID, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd1, KIND_READ, 8'h00, 8'hff, 1'b1, ST_INVALID, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd1, KIND_WRITE, 8'h00, 8'h00, 1'b1, ST_INVALID, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd1, KIND_TRIM, 8'h00, 8'hff, 1'b1, ST_INVALID, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd1, KIND_WRITE, 8'hff, 8'h00, 1'b1, ST_EXHAUSTED, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_REFUND, 4'd0, KIND_READ, 8'h00, 8'h00, 1'b1, ST_OK, READ_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd15, KIND_WRITE, 8'hff, 8'hff, 1'b1, ST_OK, WIDE_WR_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd14, KIND_FENCE, 8'h00, 8'h00, 1'b1, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd13, KIND_READ, 8'h00, 8'h07, 1'b1, ST_EXHAUSTED, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_REFUND, 4'd15, KIND_FENCE, 8'h00, 8'h00, 1'b1, ST_OK, WIDE_WR_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_REFUND, 4'd14, KIND_FENCE, 8'h00, 8'h00, 1'b1, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd2, KIND_TRIM, 8'h01, 8'h00, 1'b0, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd3, KIND_TRIM, 8'haa, 8'h55, 1'b0, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd4, KIND_WRITE, 8'h80, 8'h00, 1'b0, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd5, KIND_READ, 8'h00, 8'h03, 1'b0, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_REFUND, 4'd3, KIND_FENCE, 8'h00, 8'h00, 1'b0, ST_OK, NO_CR},
		'{1'b1, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd0, KIND_FENCE, 8'h00, 8'h00, 1'b0, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd6, KIND_WRITE, 8'h01, 8'h00, 1'b1, ST_UNKNOWN, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd6, KIND_TRIM, 8'h10, 8'h00, 1'b1, ST_UNKNOWN, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd6, KIND_READ, 8'h00, 8'h01, 1'b0, ST_OK, NO_CR},
		'{1'b1, CFG_RECORD_KNOWN, 16'd1,
			CMD_RESERVE, 4'd0, KIND_FENCE, 8'h00, 8'h00, 1'b0, ST_OK, NO_CR},
		'{1'b1, CFG_RECORD_LIMIT, 16'd0,
			CMD_RESERVE, 4'd0, KIND_FENCE, 8'h00, 8'h00, 1'b0, ST_OK, NO_CR},
		'{1'b0, CFG_RECORD_KNOWN, 16'd0,
			CMD_RESERVE, 4'd7, KIND_TRIM, 8'h02, 8'h00, 1'b1, ST_FULL, NO_CR},
		'{1'b1, CFG_RECORD_LIMIT, 16'hffff,
			CMD_RESERVE, 4'd0, KIND_FENCE, 8'h00, 8'h00, 1'b0, ST_OK, NO_CR}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  command = CMD_RESERVE;
	logic [3:0]            slot = '0;
	logic [2:0]            kind = KIND_READ;
	logic [7:0]            touch_mask = '0;
	logic [7:0]            atom_index = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            status;
	logic [5:0]            inner_cost;
	logic [4:0]            physical_cost;
	logic [4:0]            cache_cost;
	logic [4:0]            record_cost;

	logic     tag_typed = 1'b0;
	outcome_t tag_outcome = '0;

	int send_idle = 16;
	int recv_idle = 47;
	int mismatches = 0;
	int results_seen = 0;
	int activity = 0;

	outcome_t due[$];

	logic    recs_known;
	int      rec_cap;
	int      inner_cap;
	int      phys_cap;
	int      cache_cap;
	int      inner_use;
	int      phys_use;
	int      cache_use;
	int      rec_use;
	logic    booked [SLOTS];
	credit_t booking [SLOTS];

	request_credit_reserve_refund_top #(
		.SLOT_COUNT(SLOTS),
		.ATOM_COUNT(ATOMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.slot(slot),
		.kind(kind),
		.touch_mask(touch_mask),
		.atom_index(atom_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.inner_cost(inner_cost),
		.physical_cost(physical_cost),
		.cache_cost(cache_cost),
		.record_cost(record_cost)
	);

	always #1 clk = ~clk;

	function automatic outcome_t account_request(input logic cmd, input logic [3:0] sl,
			input logic [2:0] kd, input logic [7:0] mask, input logic [7:0] idx);
		outcome_t res;
		credit_t  cost;
		int       n;
		logic     well_formed;
		int       inner_top;
		int       phys_top;
		int       cache_top;
		res = '0;
		res.st = ST_OK;
		if (cmd == CMD_REFUND) begin
			if (booked[sl]) begin
				if (inner_use < booking[sl].inner || phys_use < booking[sl].physical ||
						cache_use < booking[sl].cache || rec_use < booking[sl].record) begin
					res.st = ST_INVARIANT;
				end else begin
					inner_use -= booking[sl].inner;
					phys_use -= booking[sl].physical;
					cache_use -= booking[sl].cache;
					rec_use -= booking[sl].record;
					res.cr = booking[sl];
					booked[sl] = 1'b0;
					booking[sl] = '0;
				end
			end
			return res;
		end
		cost = '0;
		well_formed = 1'b1;
		n = $countones(mask & 8'((1 << ATOMS) - 1));
		case (kd)
			KIND_READ: begin
				cost.inner = 6'd2;
				cost.cache = 5'd1;
				well_formed = (idx < ATOMS);
			end
			KIND_WRITE: begin
				well_formed = (n != 0);
				cost.inner = 6'(4 * n);
				cost.physical = 5'(2 * n);
				cost.cache = 5'(2 * n);
				cost.record = 5'(2 * n);
			end
			KIND_TRIM: begin
				well_formed = (n != 0);
				cost.inner = 6'(2 * n);
				cost.physical = 5'(n);
				cost.cache = 5'(n);
				cost.record = 5'(n);
			end
			KIND_FENCE: begin
			end
			default: begin
				well_formed = 1'b0;
			end
		endcase
		inner_top = (inner_cap < INNER_CEIL) ? inner_cap : INNER_CEIL;
		phys_top = (phys_cap < SMALL_CEIL) ? phys_cap : SMALL_CEIL;
		cache_top = (cache_cap < SMALL_CEIL) ? cache_cap : SMALL_CEIL;
		if (booked[sl] || !well_formed) begin
			res.st = ST_INVALID;
		end else if (!recs_known && (kd == KIND_WRITE || kd == KIND_TRIM)) begin
			res.st = ST_UNKNOWN;
		end else if (rec_use + cost.record > rec_cap) begin
			res.st = ST_FULL;
		end else if (inner_use + cost.inner > inner_top || phys_use + cost.physical > phys_top ||
				cache_use + cost.cache > cache_top) begin
			res.st = ST_EXHAUSTED;
		end else begin
			inner_use += cost.inner;
			phys_use += cost.physical;
			cache_use += cost.cache;
			rec_use += cost.record;
			booked[sl] = 1'b1;
			booking[sl] = cost;
			res.cr = cost;
		end
		return res;
	endfunction

	function automatic logic [3:0] pick_slot(input logic want_booked);
		logic [3:0] s;
		s = 4'($urandom_range(0, SLOTS - 1));
		for (int i = 0; i < SLOTS; i++) begin
			if (booked[s] == want_booked)
				return s;
			s = s + 4'd1;
		end
		return s;
	endfunction

	function automatic int pick_ceiling(input int sel, input int cap, input int hi);
		case (sel % PHASES)
			0: return 0;
			1: return cap;
			2: return 65535;
			default: return $urandom_range(8, hi);
		endcase
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH: %s", msg);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input int val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			CFG_RECORD_KNOWN: recs_known = val[0];
			CFG_RECORD_LIMIT: rec_cap = val & 16'hffff;
			CFG_INNER_LIMIT: inner_cap = val & 16'hffff;
			CFG_PHYSICAL_LIMIT: phys_cap = val & 16'hffff;
			CFG_CACHE_LIMIT: cache_cap = val & 16'hffff;
			default: begin
			end
		endcase
	endtask

	task automatic send_request(input logic c, input logic [3:0] s, input logic [2:0] k,
			input logic [7:0] m, input logic [7:0] a, input logic typed, input outcome_t want);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		slot <= s;
		kind <= k;
		touch_mask <= m;
		atom_index <= a;
		tag_typed <= typed;
		tag_outcome <= want;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", results_seen));
				end else begin
					want = due.pop_front();
					if (status !== want.st)
						report($sformatf("result %0d status %0d, expected %0d",
							results_seen, status, want.st));
					if (inner_cost !== want.cr.inner)
						report($sformatf("result %0d inner_cost %0d, expected %0d",
							results_seen, inner_cost, want.cr.inner));
					if (physical_cost !== want.cr.physical)
						report($sformatf("result %0d physical_cost %0d, expected %0d",
							results_seen, physical_cost, want.cr.physical));
					if (cache_cost !== want.cr.cache)
						report($sformatf("result %0d cache_cost %0d, expected %0d",
							results_seen, cache_cost, want.cr.cache));
					if (record_cost !== want.cr.record)
						report($sformatf("result %0d record_cost %0d, expected %0d",
							results_seen, record_cost, want.cr.record));
				end
			end
			if (in_valid && !in_stall) begin
				want = account_request(command, slot, kind, touch_mask, atom_index);
				due.push_back(tag_typed ? tag_outcome : want);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				activity <= activity + 1;
		end
	end

	initial begin
		int last_activity;
		int quiet;
		last_activity = 0;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (activity != last_activity) begin
				last_activity = activity;
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic       cmd;
		logic [3:0] sl;
		logic [2:0] kd;
		logic [7:0] mask;
		logic [7:0] idx;
		int         r;
		recs_known = 1'b1;
		rec_cap = 65535;
		inner_cap = 32;
		phys_cap = 16;
		cache_cap = 16;
		inner_use = 0;
		phys_use = 0;
		cache_use = 0;
		rec_use = 0;
		for (int i = 0; i < SLOTS; i++) begin
			booked[i] = 1'b0;
			booking[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(SCRIPT); i++) begin
			if (SCRIPT[i].is_cfg)
				write_register(SCRIPT[i].reg_sel, SCRIPT[i].reg_val);
			else
				send_request(SCRIPT[i].cmd, SCRIPT[i].sl, SCRIPT[i].kd, SCRIPT[i].mask,
					SCRIPT[i].idx, SCRIPT[i].typed, {SCRIPT[i].st, SCRIPT[i].cr});
		end

		for (int p = 0; p < PHASES; p++) begin
			write_register(CFG_RECORD_KNOWN, (p % 4 != 3));
			write_register(CFG_RECORD_LIMIT, pick_ceiling(p, 16, 40));
			write_register(CFG_INNER_LIMIT, pick_ceiling(p + 3, INNER_CEIL, 40));
			write_register(CFG_PHYSICAL_LIMIT, pick_ceiling(p + 6, SMALL_CEIL, 35));
			write_register(CFG_CACHE_LIMIT, pick_ceiling(p + 8, SMALL_CEIL, 35));
			if (p < 4) begin
				send_idle = 16;
				recv_idle = 47;
			end else if (p < 7) begin
				send_idle = 47;
				recv_idle = 16;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			repeat (PHASE_ITEMS) begin
				cmd = ($urandom_range(0, 99) < 40) ? CMD_REFUND : CMD_RESERVE;
				sl = ($urandom_range(0, 3) != 0) ? pick_slot(cmd == CMD_REFUND)
					: 4'($urandom_range(0, SLOTS - 1));
				r = $urandom_range(0, 19);
				kd = (r < 5) ? KIND_READ : (r < 10) ? KIND_WRITE : (r < 15) ? KIND_TRIM
					: (r < 18) ? KIND_FENCE : 3'($urandom_range(KIND_BAD, KIND_BAD_TOP));
				r = $urandom_range(0, 9);
				if (r == 0)
					mask = 8'h00;
				else if (r == 1)
					mask = 8'($urandom);
				else
					mask = 8'(1 << $urandom_range(0, ATOMS - 1))
						| ((r > 6) ? 8'(1 << $urandom_range(0, ATOMS - 1)) : 8'h00);
				idx = ($urandom_range(0, 9) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, ATOMS - 1));
				send_request(cmd, sl, kd, mask, idx, 1'b0, '0);
			end
		end

		drain();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
